@@ src/esac_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esac_pkg: encoder scan axis controller shared definitions
// Widths, register codes, drive codes and the records passed between stages.
// ----------------------------------------------------------------------------
package esac_pkg;

	localparam int ANGLE_BITS  = 18;
	localparam int NUM_AXES    = 2;
	localparam int TURN_W      = 32;
	localparam int POS_W       = TURN_W + ANGLE_BITS;
	localparam int ERR_W       = POS_W + 1;
	localparam int MAG_W       = 17;
	localparam int LVL_W       = 16;
	localparam int GAIN_W      = 20;
	localparam int SPAN_W      = 22;
	localparam int ANG_W       = 12;
	localparam int TENTHS_W    = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 22;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic signed [ANGLE_BITS:0] HALF_TURN =
		$signed((ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1));
	localparam logic [ANGLE_BITS-1:0] HALF_TURN_U = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
	localparam logic [MAG_W-1:0] ERR_CAP = MAG_W'(65536);
	localparam logic [TENTHS_W-1:0] TENTHS_PER_TURN = TENTHS_W'(3600);

	typedef enum logic [1:0] {
		DRIVE_STOP = 2'd0,
		DRIVE_FWD  = 2'd1,
		DRIVE_REV  = 2'd2
	} drive_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND  = 3'd0,
		REG_HALF_SPAN = 3'd1,
		REG_GAIN      = 3'd2,
		REG_DRIVE_MIN = 3'd3,
		REG_DRIVE_MAX = 3'd4,
		REG_START_UP  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]        deadband;
		logic [SPAN_W-1:0]  scan_half_span;
		logic [GAIN_W-1:0]  gain;
		logic [LVL_W-1:0]   drive_min;
		logic [LVL_W-1:0]   drive_max;
		logic [NUM_AXES-1:0] start_up_mask;
	} cfg_t;

	typedef struct packed {
		logic              axis;
		logic [POS_W-1:0]  pos;
		logic              homing;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} push_t;

endpackage
`default_nettype wire

@@ src/esac_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esac_in_if: encoder sample channel
// One beat carries the axis and its single-turn reading.
// ----------------------------------------------------------------------------
interface esac_in_if;
	logic        valid;
	logic        ready;
	logic        axis;
	logic [17:0] raw_angle;

	modport source (output valid, output axis, output raw_angle, input ready);
	modport sink   (input valid, input axis, input raw_angle, output ready);
endinterface
`default_nettype wire

@@ src/esac_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esac_out_if: drive result channel
// One beat carries position, angle and drive command for one axis.
// ----------------------------------------------------------------------------
interface esac_out_if;
	logic               valid;
	logic               ready;
	logic               axis_out;
	logic signed [49:0] position;
	logic signed [11:0] angle_tenths;
	logic [1:0]         drive_mode;
	logic [15:0]        drive_level;
	logic               homing;
	logic               going_up;

	modport source (output valid, output axis_out, output position, output angle_tenths,
		output drive_mode, output drive_level, output homing, output going_up,
		input ready);
	modport sink (input valid, input axis_out, input position, input angle_tenths,
		input drive_mode, input drive_level, input homing, input going_up,
		output ready);
endinterface
`default_nettype wire

@@ src/esac_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esac_front: turn tracker
// Accepts samples, tracks wraps per axis and forms the multi-turn position.
// ----------------------------------------------------------------------------
module esac_front (
	input  logic           clk,
	input  logic           arst_n,
	esac_in_if.sink        samples,
	input  logic           q_full,
	output esac_pkg::push_t push
);

	logic [esac_pkg::ANGLE_BITS-1:0] last_raw_q [esac_pkg::NUM_AXES];
	logic [esac_pkg::TURN_W-1:0]     turn_q     [esac_pkg::NUM_AXES];
	logic [esac_pkg::NUM_AXES-1:0]   homed_q;

	logic                             accept;
	logic [esac_pkg::ANGLE_BITS-1:0]  raw;
	logic signed [esac_pkg::ANGLE_BITS:0] diff;
	logic                             wrap_fwd;
	logic                             wrap_back;
	logic [esac_pkg::TURN_W-1:0]      turn_next;

	assign samples.ready = !q_full;
	assign accept        = samples.valid && !q_full;
	assign raw           = samples.raw_angle[esac_pkg::ANGLE_BITS-1:0];

	assign diff = $signed({1'b0, raw}) - $signed({1'b0, last_raw_q[samples.axis]});
	assign wrap_fwd  = homed_q[samples.axis] && (diff < -esac_pkg::HALF_TURN);
	assign wrap_back = homed_q[samples.axis] && (diff > esac_pkg::HALF_TURN);

	always_comb begin
		turn_next = turn_q[samples.axis];
		if (wrap_fwd) begin
			turn_next = turn_q[samples.axis] + esac_pkg::TURN_W'(1);
		end else if (wrap_back) begin
			turn_next = turn_q[samples.axis] - esac_pkg::TURN_W'(1);
		end
	end

	assign push.valid       = accept;
	assign push.item.axis   = samples.axis;
	assign push.item.pos    = {turn_next, raw};
	assign push.item.homing = !homed_q[samples.axis];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homed_q <= '0;
			for (int i = 0; i < esac_pkg::NUM_AXES; i++) begin
				last_raw_q[i] <= '0;
				turn_q[i]     <= '0;
			end
		end else if (accept) begin
			homed_q[samples.axis]    <= 1'b1;
			last_raw_q[samples.axis] <= raw;
			turn_q[samples.axis]     <= turn_next;
		end
	end

endmodule
`default_nettype wire

@@ src/esac_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esac_queue: position queue
// Short FIFO between turn tracker and scan controller.
// ----------------------------------------------------------------------------
module esac_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  esac_pkg::push_t push,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output esac_pkg::item_t head
);

	esac_pkg::item_t                mem_q [esac_pkg::QUEUE_DEPTH];
	logic [esac_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [esac_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [esac_pkg::QPTR_W:0]      count_q;
	logic                           do_pop;

	assign full       = count_q == (esac_pkg::QPTR_W + 1)'(esac_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + esac_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + esac_pkg::QPTR_W'(1);
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + (esac_pkg::QPTR_W + 1)'(1);
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - (esac_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ src/esac_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esac_back: scan controller and drive
// Homes axes, computes error and scan flips, then gain, clamp and angle.
// ----------------------------------------------------------------------------
module esac_back (
	input  logic            clk,
	input  logic            arst_n,
	input  esac_pkg::cfg_t  cfg,
	input  logic            head_valid,
	input  esac_pkg::item_t head,
	output logic            pop,
	esac_out_if.source      results
);

	localparam int AB = esac_pkg::ANGLE_BITS;
	localparam int PW = esac_pkg::POS_W;
	localparam int EW = esac_pkg::ERR_W;
	localparam int MW = esac_pkg::MAG_W;

	logic [PW-1:0]               home_q [esac_pkg::NUM_AXES];
	logic [PW-1:0]               tgt_q [esac_pkg::NUM_AXES];
	logic [esac_pkg::NUM_AXES-1:0] dir_q;

	// stage 1
	logic                        v_s1;
	logic                        axis_s1;
	logic [PW-1:0]               pos_s1;
	logic                        homing_s1;
	logic                        up_s1;
	esac_pkg::drive_mode_t       mode_s1;
	logic [MW-1:0]               mag_s1;
	logic [AB-1:0]               ang_mag_s1;
	logic                        ang_neg_s1;

	// stage 2 (output register)
	logic                        v_s2;
	logic                        axis_s2;
	logic [PW-1:0]               pos_s2;
	logic                        homing_s2;
	logic                        up_s2;
	esac_pkg::drive_mode_t       mode_s2;
	logic [esac_pkg::LVL_W-1:0]  lvl_s2;
	logic [esac_pkg::ANG_W-1:0]  ang_s2;

	logic ready_s1;
	logic ready_s2;

	logic                  a;
	logic [PW-1:0]         tgt;
	logic signed [EW-1:0]  err;
	logic signed [EW-1:0]  db_s;
	logic                  err_gt_db;
	logic                  err_lt_db;
	logic                  err_lt_ndb;
	logic                  err_gt_ndb;
	logic [MW-1:0]         mag_pos;
	logic [MW-1:0]         mag_neg;
	esac_pkg::drive_mode_t mode_c;
	logic [MW-1:0]         mag_c;
	logic                  dir_next;
	logic [AB-1:0]         d;
	logic [AB-1:0]         ang_mag_c;
	logic                  ang_neg_c;

	logic [MW+esac_pkg::GAIN_W-1:0]   lvl_prod;
	logic [esac_pkg::LVL_W-1:0]       lvl_c;
	logic [AB+esac_pkg::TENTHS_W-1:0] ang_prod;
	logic [esac_pkg::ANG_W-1:0]       ang_abs;

	assign ready_s2 = !v_s2 || results.ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign pop      = head_valid && ready_s1;

	assign a    = head.axis;
	assign tgt  = tgt_q[a];
	assign err  = $signed({tgt[PW-1], tgt}) - $signed({head.pos[PW-1], head.pos});
	assign db_s = $signed(EW'(cfg.deadband));

	assign err_gt_db  = err > db_s;
	assign err_lt_db  = err < db_s;
	assign err_lt_ndb = err < -db_s;
	assign err_gt_ndb = err > -db_s;

	assign mag_pos = (err >= $signed(EW'(esac_pkg::ERR_CAP))) ? esac_pkg::ERR_CAP : err[MW-1:0];
	assign mag_neg = (err <= -$signed(EW'(esac_pkg::ERR_CAP))) ? esac_pkg::ERR_CAP :
		MW'(~err[MW-1:0] + MW'(1));

	always_comb begin
		mode_c   = esac_pkg::DRIVE_STOP;
		mag_c    = '0;
		dir_next = dir_q[a];
		if (head.homing) begin
			dir_next = cfg.start_up_mask[a];
		end else begin
			if (err_gt_db) begin
				mode_c = esac_pkg::DRIVE_FWD;
				mag_c  = mag_pos;
			end else if (err_lt_ndb) begin
				mode_c = esac_pkg::DRIVE_REV;
				mag_c  = mag_neg;
			end
			if (dir_q[a] && err_lt_db) begin
				dir_next = 1'b0;
			end else if (!dir_q[a] && err_gt_ndb) begin
				dir_next = 1'b1;
			end
		end
	end

	assign d = head.pos[AB-1:0] - home_q[a][AB-1:0];

	always_comb begin
		ang_mag_c = '0;
		ang_neg_c = 1'b0;
		if (!head.homing) begin
			if (d <= esac_pkg::HALF_TURN_U) begin
				ang_mag_c = d;
			end else begin
				ang_mag_c = AB'(~d + AB'(1));
				ang_neg_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			axis_s1    <= a;
			pos_s1     <= head.pos;
			homing_s1  <= head.homing;
			up_s1      <= dir_next;
			mode_s1    <= mode_c;
			mag_s1     <= mag_c;
			ang_mag_s1 <= ang_mag_c;
			ang_neg_s1 <= ang_neg_c;
			if (head.homing) begin
				home_q[a] <= head.pos;
				tgt_q[a]  <= dir_next ? head.pos + PW'(cfg.scan_half_span) :
					head.pos - PW'(cfg.scan_half_span);
			end else if (dir_next != dir_q[a]) begin
				tgt_q[a]  <= dir_next ? home_q[a] + PW'(cfg.scan_half_span) :
					home_q[a] - PW'(cfg.scan_half_span);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (pop) begin
				dir_q[a] <= dir_next;
			end
			if (ready_s1) begin
				v_s1 <= pop;
			end
		end
	end

	// stage 2: gain, saturation, clamp and angle scaling
	assign lvl_prod = MW'(mag_s1) * esac_pkg::GAIN_W'(cfg.gain);
	assign ang_prod = (AB + esac_pkg::TENTHS_W)'(ang_mag_s1) *
		(AB + esac_pkg::TENTHS_W)'(esac_pkg::TENTHS_PER_TURN);
	assign ang_abs  = ang_prod[AB+esac_pkg::TENTHS_W-1:AB];

	always_comb begin
		logic [MW+esac_pkg::GAIN_W-17:0] shifted;
		shifted = lvl_prod[MW+esac_pkg::GAIN_W-1:16];
		if (shifted > (MW + esac_pkg::GAIN_W - 16)'(16'hFFFF)) begin
			lvl_c = 16'hFFFF;
		end else begin
			lvl_c = shifted[esac_pkg::LVL_W-1:0];
		end
		if (lvl_c > cfg.drive_max) begin
			lvl_c = cfg.drive_max;
		end
		if (lvl_c < cfg.drive_min) begin
			lvl_c = cfg.drive_min;
		end
		if (mode_s1 == esac_pkg::DRIVE_STOP) begin
			lvl_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			axis_s2   <= axis_s1;
			pos_s2    <= pos_s1;
			homing_s2 <= homing_s1;
			up_s2     <= up_s1;
			mode_s2   <= mode_s1;
			lvl_s2    <= lvl_c;
			ang_s2    <= ang_neg_s1 ? esac_pkg::ANG_W'(~ang_abs + esac_pkg::ANG_W'(1)) : ang_abs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	assign results.valid        = v_s2;
	assign results.axis_out     = axis_s2;
	assign results.position     = $signed(pos_s2);
	assign results.angle_tenths = $signed(ang_s2);
	assign results.drive_mode   = mode_s2;
	assign results.drive_level  = lvl_s2;
	assign results.homing       = homing_s2;
	assign results.going_up     = up_s2;

endmodule
`default_nettype wire

@@ src/encoder_scan_axis_controller_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_scan_axis_controller_unit: two-axis encoder scan controller
// Multi-turn tracking, homing, oscillating scan target and proportional drive.
// ----------------------------------------------------------------------------
// Usage:
//   samples: one beat per encoder reading (axis, 18-bit raw_angle).
//   results: one beat per reading with position, angle from home in tenths
//   of a degree, drive mode and level, homing flag and scan direction.
//   cfg_*: register writes; the user must write only while no beat is in flight, the block does not enforce it.
// Path: an accepted sample beat is registered in the queue, then in stage 1, then in the result register.
// Throughput: one beat per cycle while results are taken; turn tracking and the scan
//   direction and target update are per-axis register loops that need no stall.
// A two-entry queue sits between the turn tracker and the scan controller,
//   with the result register behind the scan controller. When results stall,
//   up to four beats are held in flight before samples.ready drops.
// Reset: both axes unhomed, turn counts zero, registers at their defaults;
//   the first reading of each axis after reset homes that axis.
// ----------------------------------------------------------------------------
module encoder_scan_axis_controller_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	esac_in_if.sink                            samples,
	esac_out_if.source                         results,
	input  logic                               cfg_wr_en,
	input  logic [esac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [esac_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	esac_pkg::cfg_t  cfg_q;
	esac_pkg::push_t push;
	esac_pkg::item_t head;
	logic            q_full;
	logic            head_valid;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband       <= 16'd256;
			cfg_q.scan_half_span <= esac_pkg::SPAN_W'(65536);
			cfg_q.gain           <= esac_pkg::GAIN_W'(655);
			cfg_q.drive_min      <= '0;
			cfg_q.drive_max      <= 16'hFFFF;
			cfg_q.start_up_mask  <= 2'b10;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				esac_pkg::REG_DEADBAND:  cfg_q.deadband       <= cfg_wdata[15:0];
				esac_pkg::REG_HALF_SPAN: cfg_q.scan_half_span <= cfg_wdata[esac_pkg::SPAN_W-1:0];
				esac_pkg::REG_GAIN:      cfg_q.gain           <= cfg_wdata[esac_pkg::GAIN_W-1:0];
				esac_pkg::REG_DRIVE_MIN: cfg_q.drive_min      <= cfg_wdata[15:0];
				esac_pkg::REG_DRIVE_MAX: cfg_q.drive_max      <= cfg_wdata[15:0];
				esac_pkg::REG_START_UP:  cfg_q.start_up_mask  <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	esac_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.q_full  (q_full),
		.push    (push)
	);

	esac_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	esac_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

endmodule
`default_nettype wire

@@ src/esac_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esac_checker: result channel checks
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module esac_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [49:0] position,
	input logic signed [11:0] angle_tenths,
	input logic [1:0]         drive_mode,
	input logic [15:0]        drive_level,
	input logic               homing
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(position) && $stable(drive_level))
		else $error("result beat changed while stalled");

	a_stop_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && drive_mode == esac_pkg::DRIVE_STOP |-> drive_level == 16'd0)
		else $error("nonzero drive level while stopped");

	a_homing_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && homing |-> drive_mode == esac_pkg::DRIVE_STOP && angle_tenths == 12'sd0)
		else $error("homing beat with drive or angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> angle_tenths >= -12'sd1799 && angle_tenths <= 12'sd1800)
		else $error("angle out of range");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> drive_mode == esac_pkg::DRIVE_STOP || drive_mode == esac_pkg::DRIVE_FWD ||
			drive_mode == esac_pkg::DRIVE_REV)
		else $error("invalid drive mode");

endmodule

bind encoder_scan_axis_controller_unit esac_checker u_esac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (results.valid),
	.res_ready    (results.ready),
	.position     (results.position),
	.angle_tenths (results.angle_tenths),
	.drive_mode   (results.drive_mode),
	.drive_level  (results.drive_level),
	.homing       (results.homing)
);
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: encoder scan axis controller unit
// Sends encoder readings for both axes. A directed opener covers homing,
// turn wraps, deadband edges and angle extremes. Scan walks with random
// steps and noise follow, under several register settings. Every result beat
// is checked field by field against a cycle-free model of turn tracking,
// homing, the scan legs and the proportional drive.
// ----------------------------------------------------------------------------
module testbench;

	localparam int HALF_REV = 1 << (esac_pkg::ANGLE_BITS - 1);
	localparam int REV = 1 << esac_pkg::ANGLE_BITS;
	localparam longint MAG_CAP = 65536;
	localparam int PHASE_ITEMS = 185;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic        axis;
		logic [17:0] raw;
	} reading_t;

	typedef struct packed {
		logic                       axis;
		logic [esac_pkg::POS_W-1:0] position;
		logic [11:0]                angle_tenths;
		esac_pkg::drive_mode_t      mode;
		logic [15:0]                level;
		logic                       homing;
		logic                       going_up;
	} drive_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [esac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [esac_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_axis = 1'b0;
	logic [17:0] in_raw = '0;
	logic out_ready = 1'b0;

	esac_in_if samples_if ();
	esac_out_if results_if ();

	assign samples_if.valid = in_valid;
	assign samples_if.axis = in_axis;
	assign samples_if.raw_angle = in_raw;
	assign results_if.ready = out_ready;

	encoder_scan_axis_controller_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// register shadow
	logic [15:0]                   db_cfg = 16'd256;
	logic [esac_pkg::SPAN_W-1:0]   span_cfg = 22'd65536;
	logic [esac_pkg::GAIN_W-1:0]   gain_cfg = 20'd655;
	logic [15:0]                   min_cfg = 16'd0;
	logic [15:0]                   max_cfg = 16'hFFFF;
	logic [esac_pkg::NUM_AXES-1:0] mask_cfg = 2'd2;

	// per-axis tracker state
	logic [17:0]                last_raw [esac_pkg::NUM_AXES] = '{default: '0};
	logic [31:0]                turns [esac_pkg::NUM_AXES] = '{default: '0};
	logic                       homed [esac_pkg::NUM_AXES] = '{default: 1'b0};
	logic [esac_pkg::POS_W-1:0] home_pos [esac_pkg::NUM_AXES] = '{default: '0};
	logic [esac_pkg::POS_W-1:0] target_pos [esac_pkg::NUM_AXES] = '{default: '0};
	logic                       dir_up [esac_pkg::NUM_AXES] = '{default: 1'b0};

	// scan walk used to build stimulus
	longint walk_pos [esac_pkg::NUM_AXES];
	longint walk_home [esac_pkg::NUM_AXES];
	bit     walk_up [esac_pkg::NUM_AXES];

	reading_t   reading_q [$];
	drive_rec_t expected_q [$];
	reading_t   next_reading;
	drive_rec_t due;

	int  queued_total = 0;
	int  results_seen = 0;
	int  mismatches = 0;
	int  stall_cycles = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  in_taken = 1'b0;
	bit  out_taken = 1'b0;

	always #6 clk = ~clk;

	function automatic logic [15:0] level_for(longint mag);
		longint prod;
		logic [15:0] lvl;
		prod = ((mag > MAG_CAP ? MAG_CAP : mag) * longint'(gain_cfg)) >> 16;
		lvl = (prod > 65535) ? 16'hFFFF : 16'(prod);
		if (lvl > max_cfg) lvl = max_cfg;
		if (lvl < min_cfg) lvl = min_cfg;
		return lvl;
	endfunction

	function automatic drive_rec_t track_reading(logic axis, logic [17:0] raw);
		drive_rec_t r;
		int a;
		longint diff, err, db;
		logic [esac_pkg::POS_W-1:0] pos, rel;
		logic [17:0] d;
		a = int'(axis);
		r = '0;
		r.axis = axis;
		r.mode = esac_pkg::DRIVE_STOP;
		if (homed[a]) begin
			diff = longint'(raw) - longint'(last_raw[a]);
			if (diff < -HALF_REV) turns[a] = turns[a] + 32'd1;
			else if (diff > HALF_REV) turns[a] = turns[a] - 32'd1;
		end
		last_raw[a] = raw;
		pos = {turns[a], raw};
		if (!homed[a]) begin
			homed[a] = 1'b1;
			home_pos[a] = pos;
			dir_up[a] = mask_cfg[a];
			target_pos[a] = mask_cfg[a] ? pos + esac_pkg::POS_W'(span_cfg) :
				pos - esac_pkg::POS_W'(span_cfg);
			r.homing = 1'b1;
		end else begin
			rel = pos - home_pos[a];
			d = rel[17:0];
			if (d <= 18'(HALF_REV)) begin
				r.angle_tenths = 12'((int'(d) * 3600) >> esac_pkg::ANGLE_BITS);
			end else begin
				r.angle_tenths = 12'(-(((REV - int'(d)) * 3600) >> esac_pkg::ANGLE_BITS));
			end
			err = longint'($signed(target_pos[a])) - longint'($signed(pos));
			db = longint'(db_cfg);
			if (err > db) begin
				r.mode = esac_pkg::DRIVE_FWD;
				r.level = level_for(err);
			end else if (err < -db) begin
				r.mode = esac_pkg::DRIVE_REV;
				r.level = level_for(-err);
			end
			if (dir_up[a] && err < db) begin
				dir_up[a] = 1'b0;
				target_pos[a] = home_pos[a] - esac_pkg::POS_W'(span_cfg);
			end else if (!dir_up[a] && err > -db) begin
				dir_up[a] = 1'b1;
				target_pos[a] = home_pos[a] + esac_pkg::POS_W'(span_cfg);
			end
		end
		r.position = pos;
		r.going_up = dir_up[a];
		return r;
	endfunction

	task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
		mismatches++;
	endtask

	task automatic queue_reading(logic axis, logic [17:0] raw);
		reading_q.push_back({axis, raw});
		queued_total++;
	endtask

	task automatic write_reg(esac_pkg::cfg_reg_t idx, logic [esac_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			esac_pkg::REG_DEADBAND: db_cfg = value[15:0];
			esac_pkg::REG_HALF_SPAN: span_cfg = value[esac_pkg::SPAN_W-1:0];
			esac_pkg::REG_GAIN: gain_cfg = value[esac_pkg::GAIN_W-1:0];
			esac_pkg::REG_DRIVE_MIN: min_cfg = value[15:0];
			esac_pkg::REG_DRIVE_MAX: max_cfg = value[15:0];
			esac_pkg::REG_START_UP: mask_cfg = value[esac_pkg::NUM_AXES-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(int db, int span, int gn, int lo, int hi, int mask);
		write_reg(esac_pkg::REG_DEADBAND, esac_pkg::CFG_DATA_W'(db));
		write_reg(esac_pkg::REG_HALF_SPAN, esac_pkg::CFG_DATA_W'(span));
		write_reg(esac_pkg::REG_GAIN, esac_pkg::CFG_DATA_W'(gn));
		write_reg(esac_pkg::REG_DRIVE_MIN, esac_pkg::CFG_DATA_W'(lo));
		write_reg(esac_pkg::REG_DRIVE_MAX, esac_pkg::CFG_DATA_W'(hi));
		write_reg(esac_pkg::REG_START_UP, esac_pkg::CFG_DATA_W'(mask));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain_results();
		while (results_seen != queued_total) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// scan legs toward home +/- span, with landings on the deadband edges
	// and a share of arbitrary readings
	task automatic queue_scan(int count);
		int a, roll, step_lim;
		longint goal, next, jump, off;
		logic [17:0] raw;
		step_lim = int'(span_cfg) / 4;
		if (step_lim < 2000) step_lim = 2000;
		if (step_lim > 100000) step_lim = 100000;
		for (a = 0; a < esac_pkg::NUM_AXES; a++) begin
			walk_pos[a] = longint'($signed({turns[a], last_raw[a]}));
			walk_home[a] = longint'($signed(home_pos[a]));
			walk_up[a] = dir_up[a];
		end
		repeat (count) begin
			a = $urandom_range(0, esac_pkg::NUM_AXES - 1);
			roll = $urandom_range(0, 99);
			goal = walk_home[a] + (walk_up[a] ? longint'(span_cfg) : -longint'(span_cfg));
			if (roll < 8) begin
				raw = 18'($urandom_range(0, REV - 1));
				walk_pos[a] += longint'($signed(raw - 18'(walk_pos[a])));
			end else begin
				if (roll < 20) begin
					off = longint'(db_cfg) + $urandom_range(0, 2) - 1;
					next = goal + (roll[0] ? off : -off);
				end else begin
					jump = $urandom_range(0, step_lim);
					if (roll < 30) jump = -jump;
					next = walk_pos[a] + (walk_up[a] ? jump : -jump);
				end
				if (next - walk_pos[a] >= HALF_REV) next = walk_pos[a] + HALF_REV - 1;
				else if (next - walk_pos[a] <= -HALF_REV) next = walk_pos[a] - HALF_REV + 1;
				walk_pos[a] = next;
				raw = 18'(next);
				if (walk_up[a] ? next >= goal : next <= goal) walk_up[a] = !walk_up[a];
			end
			queue_reading(a[0], raw);
		end
	endtask

	task automatic run_phase(int db, int span, int gn, int lo, int hi, int mask,
		int send_pct, int recv_pct);
		drain_results();
		program_regs(db, span, gn, lo, hi, mask);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		queue_scan(PHASE_ITEMS);
	endtask

	// driver: a beat stays up until taken
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (!in_valid || in_taken) begin
			if (reading_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_reading = reading_q.pop_front();
				in_valid <= 1'b1;
				in_axis <= next_reading.axis;
				in_raw <= next_reading.raw;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: predict on sample beats, check result beats
	always @(posedge clk) begin
		in_taken = in_valid && samples_if.ready;
		out_taken = results_if.valid && out_ready;
		if (in_taken) expected_q.push_back(track_reading(in_axis, in_raw));
		if (out_taken) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				flag_mismatch("unexpected beat", 64'(results_if.position), '0);
			end else begin
				due = expected_q.pop_front();
				if (results_if.axis_out !== due.axis)
					flag_mismatch("axis_out", 64'(results_if.axis_out), 64'(due.axis));
				if (results_if.position !== due.position)
					flag_mismatch("position", 64'(results_if.position), 64'(due.position));
				if (results_if.angle_tenths !== due.angle_tenths)
					flag_mismatch("angle_tenths", 64'(results_if.angle_tenths),
						64'(due.angle_tenths));
				if (results_if.drive_mode !== due.mode)
					flag_mismatch("drive_mode", 64'(results_if.drive_mode), 64'(due.mode));
				if (results_if.drive_level !== due.level)
					flag_mismatch("drive_level", 64'(results_if.drive_level), 64'(due.level));
				if (results_if.homing !== due.homing)
					flag_mismatch("homing", 64'(results_if.homing), 64'(due.homing));
				if (results_if.going_up !== due.going_up)
					flag_mismatch("going_up", 64'(results_if.going_up), 64'(due.going_up));
			end
		end
		stall_cycles = (in_taken || out_taken) ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("encoder_scan_axis_controller_unit test failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		program_regs(256, 65536, 655, 0, 65535, 1);
		send_idle_pct = 36;
		recv_idle_pct = 67;

		// axis 0 homes at 0 going up; steps of exactly half a turn (no wrap) and just past it (wrap)
		queue_reading(1'b0, 18'd0);
		queue_reading(1'b0, 18'd262143);
		queue_reading(1'b0, 18'd131071);
		queue_reading(1'b0, 18'd262143);
		queue_reading(1'b0, 18'd131070);
		queue_reading(1'b0, 18'd0);
		queue_reading(1'b0, 18'd131073);
		queue_reading(1'b0, 18'd131072);
		// axis 1 homes at full scale going down; deadband edges on both legs
		queue_reading(1'b1, 18'd262143);
		queue_reading(1'b1, 18'd262143);
		queue_reading(1'b1, 18'd196863);
		queue_reading(1'b1, 18'd196862);
		queue_reading(1'b1, 18'd65279);
		queue_reading(1'b1, 18'd65280);
		queue_reading(1'b0, 18'd262143);
		queue_reading(1'b1, 18'd0);
		queue_reading(1'b0, 18'd65536);
		queue_reading(1'b1, 18'd131072);

		run_phase(0, 0, 20'hFFFFF, 0, 16'hFFFF, 0, 36, 67);
		run_phase(16'hFFFF, 22'h3FFFFF, 0, 16'hFFFF, 0, 3, 36, 67);
		run_phase(100, 3000, 65536, 500, 40000, 2, 67, 36);
		run_phase(1000, 200000, 20'hFFFFF, 0, 16'hFFFF, 1, 67, 36);
		run_phase($urandom_range(0, 65535), $urandom_range(0, 300000),
			$urandom_range(0, 20'hFFFFF), $urandom_range(0, 8000),
			$urandom_range(8000, 65535), $urandom_range(0, 3), 0, 0);
		run_phase($urandom_range(0, 22'h3FFFFF), $urandom_range(0, 22'h3FFFFF),
			$urandom_range(0, 22'h3FFFFF), $urandom_range(0, 22'h3FFFFF),
			$urandom_range(0, 22'h3FFFFF), $urandom_range(0, 22'h3FFFFF), 0, 0);
		run_phase(256, 65536, 655, 0, 65535, 2, 0, 0);
		drain_results();

		if (expected_q.size() != 0) flag_mismatch("missing beats", 64'(expected_q.size()), '0);
		if (mismatches == 0) begin
			$display("encoder_scan_axis_controller_unit test passed");
		end else begin
			$display("encoder_scan_axis_controller_unit test failed");
		end
		$finish;
	end

endmodule
